FILE: rtl/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg: shared types and codes of the first-fit heap allocator
// Holds the operation and error codes, the sequencer states and the layout of
// one table entry (block start and payload size).
// ----------------------------------------------------------------------------
package ffa_pkg;

	// Operation codes carried in the func field.
	localparam logic [1:0] FUNC_ALLOC  = 2'd0;
	localparam logic [1:0] FUNC_FREE   = 2'd1;
	localparam logic [1:0] FUNC_SIZE   = 2'd2;
	localparam logic [1:0] FUNC_STATUS = 2'd3;

	// Error codes reported with every result word.
	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_NOFIT   = 2'd1;
	localparam logic [1:0] ERR_FULL    = 2'd2;
	localparam logic [1:0] ERR_UNKNOWN = 2'd3;

	// Heap size after reset and its upper clamp.
	localparam logic [16:0] HEAP_MAX = 17'd65536;

	// One entry of the free list or of the allocated table.
	typedef struct packed {
		logic [15:0] start;
		logic [15:0] payload;
	} ffa_entry_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_RND,
		ST_SIZE,
		ST_ASCAN,
		ST_ATAKE,
		ST_TSCAN,
		ST_FSCAN,
		ST_FDEC,
		ST_DEL,
		ST_INS,
		ST_RESP
	} ffa_state_t;

endpackage

FILE: rtl/ffa_if.sv
// ----------------------------------------------------------------------------
// ffa_req_if / ffa_rsp_if: request and result channels of the allocator
// Valid/ready channels; a word moves at a clock edge with both high.
// ----------------------------------------------------------------------------
interface ffa_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [16:0] request_bytes;
	logic [15:0] block_address;

	modport source (output valid, func, request_bytes, block_address, input ready);
	modport sink   (input valid, func, request_bytes, block_address, output ready);
endinterface

interface ffa_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] granted_address;
	logic [15:0] block_bytes;
	logic        ok;
	logic [1:0]  error_code;
	logic [15:0] total_free_bytes;
	logic [5:0]  fragment_count;

	modport source (output valid, granted_address, block_bytes, ok, error_code,
		total_free_bytes, fragment_count, input ready);
	modport sink   (input valid, granted_address, block_bytes, ok, error_code,
		total_free_bytes, fragment_count, output ready);
endinterface

FILE: rtl/ffa_ram.sv
// ----------------------------------------------------------------------------
// ffa_ram: synchronous memory with one write and one read port
// Read data is registered, so it appears in the cycle after the address.
// ----------------------------------------------------------------------------
module ffa_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/ffa_seq.sv
// ----------------------------------------------------------------------------
// ffa_seq: operation sequencer of the allocator
// Scans the free list and the allocated table one entry a cycle through their
// memories, moves entries for inserts and deletes, and keeps the counters.
// ----------------------------------------------------------------------------
module ffa_seq #(
	parameter int FREE_SLOTS   = 32,
	parameter int TAKEN_SLOTS  = 32,
	parameter int ALIGN_BYTES  = 8,
	parameter int HEADER_BYTES = 8,
	parameter int FI_W = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1,
	parameter int TI_W = (TAKEN_SLOTS > 1) ? $clog2(TAKEN_SLOTS) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	ffa_req_if.sink             req,
	ffa_rsp_if.source           rsp,
	input  logic                cfg_wen,
	input  logic [16:0]         cfg_wdata,
	// Free list memory.
	output logic                fr_we,
	output logic [FI_W-1:0]     fr_waddr,
	output ffa_pkg::ffa_entry_t fr_wdata,
	output logic [FI_W-1:0]     fr_raddr,
	input  ffa_pkg::ffa_entry_t fr_rdata,
	// Allocated table memory.
	output logic                tk_we,
	output logic [TI_W-1:0]     tk_waddr,
	output ffa_pkg::ffa_entry_t tk_wdata,
	output logic [TI_W-1:0]     tk_raddr,
	input  ffa_pkg::ffa_entry_t tk_rdata
);

	localparam int FC_W  = $clog2(FREE_SLOTS + 1);
	localparam int TC_W  = $clog2(TAKEN_SLOTS + 1);
	localparam int SH    = 24;
	localparam int RECIP = (2**SH + ALIGN_BYTES - 1) / ALIGN_BYTES;
	localparam logic [15:0] HB16 = 16'(HEADER_BYTES);
	localparam logic [17:0] HB18 = 18'(HEADER_BYTES);
	localparam logic [FC_W-1:0] FREE_FULL  = FC_W'(FREE_SLOTS);
	localparam logic [TC_W-1:0] TAKEN_FULL = TC_W'(TAKEN_SLOTS);
	localparam logic [TI_W-1:0] TAKEN_LAST = TI_W'(TAKEN_SLOTS - 1);

	ffa_pkg::ffa_state_t state_q, state_d;

	// Control state.
	logic [FC_W-1:0]        used_q;
	logic [TAKEN_SLOTS-1:0] tvalid_q;
	logic [TC_W-1:0]        tcnt_q;
	logic                   chk_s1;
	logic                   tchk_s1;
	logic                   out_valid_q;
	logic [16:0]            heap_q;

	// Operation registers.
	logic [1:0]          op_q;
	logic [16:0]         req_q;
	logic [15:0]         addr_q;
	logic [17:0]         q_q;
	logic [17:0]         size_q;
	logic [FC_W-1:0]     idx_q;
	logic [FC_W-1:0]     cidx_s1;
	logic [FC_W-1:0]     pos_q;
	logic [TC_W-1:0]     tj_q;
	logic [TI_W-1:0]     tcidx_s1;
	logic [TI_W-1:0]     tidx_q;
	logic [TI_W-1:0]     thit_q;
	ffa_pkg::ffa_entry_t hit_q;
	ffa_pkg::ffa_entry_t prev_q;
	ffa_pkg::ffa_entry_t next_q;
	logic                has_next_q;
	logic [15:0]         ts_q;
	logic [15:0]         tp_q;
	logic [15:0]         total_q;
	logic [15:0]         gaddr_q;
	logic [15:0]         bytes_q;
	logic [1:0]          err_q;

	// Result register.
	logic [15:0] o_gaddr_q;
	logic [15:0] o_bytes_q;
	logic [1:0]  o_err_q;
	logic [15:0] o_total_q;
	logic [5:0]  o_frag_q;

	// Decision flags.
	logic        accept;
	logic        out_load;
	logic        a_hit;
	logic        f_more;
	logic        fs_hit;
	logic        ins_more;
	logic        tk_hit;
	logic        t_more;
	logic        t_full;
	logic        slot_ok;
	logic        whole;
	logic        mnext;
	logic        mprev;
	logic [16:0] eff;
	logic [15:0] pay0;
	logic [16:0] end_a;
	logic [17:0] nsum;
	logic [42:0] prod;

	assign accept   = req.valid && req.ready;
	assign out_load = (state_q == ffa_pkg::ST_RESP) && (!out_valid_q || rsp.ready);
	assign a_hit    = chk_s1 && ({2'b0, fr_rdata.payload} >= size_q);
	assign f_more   = idx_q < used_q;
	assign fs_hit   = chk_s1 && (fr_rdata.start > ts_q);
	assign ins_more = idx_q > pos_q;
	assign tk_hit   = tchk_s1 && tvalid_q[tcidx_s1] &&
		(({1'b0, tk_rdata.start} + {1'b0, HB16}) == {1'b0, addr_q});
	assign t_more   = tj_q < TAKEN_FULL;
	assign t_full   = tcnt_q == TAKEN_FULL;
	assign slot_ok  = !t_full && !tvalid_q[tidx_q];
	assign whole    = {2'b0, hit_q.payload} < (size_q + HB18);
	assign end_a    = {1'b0, ts_q} + {1'b0, HB16} + {1'b0, tp_q};
	assign mnext    = has_next_q && ({1'b0, next_q.start} == end_a);
	assign mprev    = (pos_q != '0) &&
		(({1'b0, prev_q.start} + {1'b0, HB16} + {1'b0, prev_q.payload}) == {1'b0, ts_q});

	// Payload of the single free block after initialisation; sizes are clamped.
	assign eff  = heap_q[16] ? ffa_pkg::HEAP_MAX : heap_q;
	assign pay0 = (eff >= 17'(HEADER_BYTES)) ? 16'(eff - 17'(HEADER_BYTES)) : 16'd0;

	// Rounding up by a multiply with the reciprocal of the alignment.
	assign nsum = {1'b0, req_q} + 18'(ALIGN_BYTES - 1);
	assign prod = {25'b0, nsum} * 43'(RECIP);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ffa_pkg::ST_INIT: state_d = ffa_pkg::ST_IDLE;
			ffa_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (req.func)
						ffa_pkg::FUNC_ALLOC:  state_d = ffa_pkg::ST_RND;
						ffa_pkg::FUNC_FREE,
						ffa_pkg::FUNC_SIZE:   state_d = ffa_pkg::ST_TSCAN;
						ffa_pkg::FUNC_STATUS: state_d = ffa_pkg::ST_RESP;
						default:              state_d = ffa_pkg::ST_RESP;
					endcase
				end
			end
			ffa_pkg::ST_RND:  state_d = ffa_pkg::ST_SIZE;
			ffa_pkg::ST_SIZE: state_d = ffa_pkg::ST_ASCAN;
			ffa_pkg::ST_ASCAN: begin
				if (a_hit) begin
					state_d = ffa_pkg::ST_ATAKE;
				end else if (!f_more && !chk_s1) begin
					state_d = ffa_pkg::ST_RESP;
				end
			end
			ffa_pkg::ST_ATAKE: begin
				if (t_full) begin
					state_d = ffa_pkg::ST_RESP;
				end else if (slot_ok) begin
					state_d = whole ? ffa_pkg::ST_DEL : ffa_pkg::ST_RESP;
				end
			end
			ffa_pkg::ST_TSCAN: begin
				if (tk_hit) begin
					state_d = (op_q == ffa_pkg::FUNC_FREE) ? ffa_pkg::ST_FSCAN
						: ffa_pkg::ST_RESP;
				end else if (!t_more && !tchk_s1) begin
					state_d = ffa_pkg::ST_RESP;
				end
			end
			ffa_pkg::ST_FSCAN: begin
				if (fs_hit || (!f_more && !chk_s1)) begin
					state_d = ffa_pkg::ST_FDEC;
				end
			end
			ffa_pkg::ST_FDEC: begin
				if (mnext && mprev) begin
					state_d = ffa_pkg::ST_DEL;
				end else if (mnext || mprev || used_q >= FREE_FULL) begin
					state_d = ffa_pkg::ST_RESP;
				end else begin
					state_d = ffa_pkg::ST_INS;
				end
			end
			ffa_pkg::ST_DEL: begin
				if (!f_more && !chk_s1) begin
					state_d = ffa_pkg::ST_RESP;
				end
			end
			ffa_pkg::ST_INS: begin
				if (!ins_more && !chk_s1) begin
					state_d = ffa_pkg::ST_RESP;
				end
			end
			ffa_pkg::ST_RESP: begin
				if (out_load) begin
					state_d = ffa_pkg::ST_IDLE;
				end
			end
			default: state_d = ffa_pkg::ST_INIT;
		endcase
		if (cfg_wen) begin
			state_d = ffa_pkg::ST_INIT;
		end
	end

	// Memory port control.
	always_comb begin
		fr_we    = 1'b0;
		fr_waddr = '0;
		fr_wdata = '0;
		fr_raddr = idx_q[FI_W-1:0];
		tk_we    = 1'b0;
		tk_waddr = tidx_q;
		tk_wdata = '0;
		tk_raddr = tj_q[TI_W-1:0];
		unique case (state_q)
			ffa_pkg::ST_INIT: begin
				fr_we    = 1'b1;
				fr_wdata = '{start: 16'd0, payload: pay0};
			end
			ffa_pkg::ST_ATAKE: begin
				if (slot_ok) begin
					tk_we    = 1'b1;
					tk_wdata = '{start: hit_q.start,
						payload: whole ? hit_q.payload : size_q[15:0]};
					if (!whole) begin
						fr_we    = 1'b1;
						fr_waddr = pos_q[FI_W-1:0];
						fr_wdata = '{start: 16'(hit_q.start + HB16 + size_q[15:0]),
							payload: 16'(hit_q.payload - HB16 - size_q[15:0])};
					end
				end
			end
			ffa_pkg::ST_FDEC: begin
				if (mnext && mprev) begin
					fr_we    = 1'b1;
					fr_waddr = FI_W'(pos_q - 1'b1);
					fr_wdata = '{start: prev_q.start,
						payload: 16'(prev_q.payload + HB16 + HB16 + tp_q + next_q.payload)};
				end else if (mprev) begin
					fr_we    = 1'b1;
					fr_waddr = FI_W'(pos_q - 1'b1);
					fr_wdata = '{start: prev_q.start,
						payload: 16'(prev_q.payload + HB16 + tp_q)};
				end else if (mnext) begin
					fr_we    = 1'b1;
					fr_waddr = pos_q[FI_W-1:0];
					fr_wdata = '{start: ts_q, payload: 16'(tp_q + HB16 + next_q.payload)};
				end
			end
			ffa_pkg::ST_DEL: begin
				// Each entry read last cycle moves one place down.
				if (chk_s1) begin
					fr_we    = 1'b1;
					fr_waddr = FI_W'(cidx_s1 - 1'b1);
					fr_wdata = fr_rdata;
				end
			end
			ffa_pkg::ST_INS: begin
				// Entries move up from the top; the new block goes in last.
				// The entry read last cycle sat one below cidx_s1, so it lands there.
				fr_raddr = FI_W'(idx_q - 1'b1);
				if (chk_s1) begin
					fr_we    = 1'b1;
					fr_waddr = FI_W'(cidx_s1);
					fr_wdata = fr_rdata;
				end else if (!ins_more) begin
					fr_we    = 1'b1;
					fr_waddr = pos_q[FI_W-1:0];
					fr_wdata = '{start: ts_q, payload: tp_q};
				end
			end
			default: ;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ffa_pkg::ST_INIT;
			used_q      <= FC_W'(1);
			tvalid_q    <= '0;
			tcnt_q      <= '0;
			chk_s1      <= 1'b0;
			tchk_s1     <= 1'b0;
			out_valid_q <= 1'b0;
			heap_q      <= ffa_pkg::HEAP_MAX;
		end else begin
			state_q <= state_d;
			chk_s1  <= 1'b0;
			tchk_s1 <= 1'b0;
			if (cfg_wen) begin
				heap_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ffa_pkg::ST_INIT: begin
					used_q   <= FC_W'(1);
					tvalid_q <= '0;
					tcnt_q   <= '0;
				end
				ffa_pkg::ST_ASCAN: chk_s1 <= !a_hit && f_more;
				ffa_pkg::ST_FSCAN: chk_s1 <= !fs_hit && f_more;
				ffa_pkg::ST_DEL: begin
					chk_s1 <= f_more;
					if (!f_more && !chk_s1) begin
						used_q <= used_q - 1'b1;
					end
				end
				ffa_pkg::ST_INS: begin
					chk_s1 <= ins_more;
					if (!ins_more && !chk_s1) begin
						used_q <= used_q + 1'b1;
					end
				end
				ffa_pkg::ST_TSCAN: tchk_s1 <= !tk_hit && t_more;
				ffa_pkg::ST_ATAKE: begin
					if (slot_ok) begin
						tvalid_q[tidx_q] <= 1'b1;
						tcnt_q           <= tcnt_q + 1'b1;
					end
				end
				ffa_pkg::ST_FDEC: begin
					if (mnext || mprev || used_q < FREE_FULL) begin
						tvalid_q[thit_q] <= 1'b0;
						tcnt_q           <= tcnt_q - 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Operation datapath.
	always_ff @(posedge clk) begin
		cidx_s1  <= idx_q;
		tcidx_s1 <= tj_q[TI_W-1:0];
		unique case (state_q)
			ffa_pkg::ST_INIT: total_q <= pay0;
			ffa_pkg::ST_IDLE: begin
				op_q    <= req.func;
				req_q   <= req.request_bytes;
				addr_q  <= req.block_address;
				idx_q   <= '0;
				tj_q    <= '0;
				tidx_q  <= '0;
				gaddr_q <= '0;
				bytes_q <= '0;
				err_q   <= ffa_pkg::ERR_NONE;
			end
			ffa_pkg::ST_RND:  q_q    <= 18'(prod >> SH);
			ffa_pkg::ST_SIZE: size_q <= 18'(q_q * 18'(ALIGN_BYTES));
			ffa_pkg::ST_ASCAN: begin
				if (tvalid_q[tidx_q] && tidx_q != TAKEN_LAST) begin
					tidx_q <= tidx_q + 1'b1;
				end
				if (a_hit) begin
					pos_q <= cidx_s1;
					hit_q <= fr_rdata;
				end else if (f_more) begin
					idx_q <= idx_q + 1'b1;
				end else if (!chk_s1) begin
					err_q <= ffa_pkg::ERR_NOFIT;
				end
			end
			ffa_pkg::ST_ATAKE: begin
				if (tvalid_q[tidx_q] && tidx_q != TAKEN_LAST) begin
					tidx_q <= tidx_q + 1'b1;
				end
				if (t_full) begin
					err_q <= ffa_pkg::ERR_FULL;
				end else if (slot_ok) begin
					gaddr_q <= hit_q.start + HB16;
					idx_q   <= pos_q + 1'b1;
					if (whole) begin
						bytes_q <= hit_q.payload;
						total_q <= total_q - hit_q.payload;
					end else begin
						bytes_q <= size_q[15:0];
						total_q <= 16'(total_q - HB16 - size_q[15:0]);
					end
				end
			end
			ffa_pkg::ST_TSCAN: begin
				if (tk_hit) begin
					thit_q  <= tcidx_s1;
					ts_q    <= tk_rdata.start;
					tp_q    <= tk_rdata.payload;
					prev_q  <= '0;
					if (op_q == ffa_pkg::FUNC_SIZE) begin
						bytes_q <= tk_rdata.payload;
					end
				end else if (t_more) begin
					tj_q <= tj_q + 1'b1;
				end else if (!tchk_s1) begin
					err_q <= ffa_pkg::ERR_UNKNOWN;
				end
			end
			ffa_pkg::ST_FSCAN: begin
				if (fs_hit) begin
					pos_q      <= cidx_s1;
					next_q     <= fr_rdata;
					has_next_q <= 1'b1;
				end else begin
					if (chk_s1) begin
						prev_q <= fr_rdata;
					end
					if (f_more) begin
						idx_q <= idx_q + 1'b1;
					end else if (!chk_s1) begin
						pos_q      <= used_q;
						has_next_q <= 1'b0;
					end
				end
			end
			ffa_pkg::ST_FDEC: begin
				if (mnext && mprev) begin
					total_q <= 16'(total_q + HB16 + HB16 + tp_q);
					idx_q   <= pos_q + 1'b1;
				end else if (mnext || mprev) begin
					total_q <= 16'(total_q + HB16 + tp_q);
				end else if (used_q >= FREE_FULL) begin
					err_q <= ffa_pkg::ERR_FULL;
				end else begin
					total_q <= total_q + tp_q;
					idx_q   <= used_q;
				end
			end
			ffa_pkg::ST_DEL: begin
				if (f_more) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			ffa_pkg::ST_INS: begin
				if (ins_more) begin
					idx_q <= idx_q - 1'b1;
				end
			end
			ffa_pkg::ST_RESP: begin
				if (out_load) begin
					o_gaddr_q <= gaddr_q;
					o_bytes_q <= bytes_q;
					o_err_q   <= err_q;
					o_total_q <= total_q;
					o_frag_q  <= 6'({{(32 - FC_W){1'b0}}, used_q} + 32'd1);
				end
			end
			default: ;
		endcase
	end

	// Channel outputs.
	assign req.ready            = state_q == ffa_pkg::ST_IDLE;
	assign rsp.valid            = out_valid_q;
	assign rsp.granted_address  = o_gaddr_q;
	assign rsp.block_bytes      = o_bytes_q;
	assign rsp.ok               = o_err_q == ffa_pkg::ERR_NONE;
	assign rsp.error_code       = o_err_q;
	assign rsp.total_free_bytes = o_total_q;
	assign rsp.fragment_count   = o_frag_q;

	// The free list never overflows; it may empty when its last entry is taken whole.
	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= FREE_FULL)
		else $error("free list count out of range");

	// The allocated count tracks the valid bits.
	a_tcnt: assert property (@(posedge clk) disable iff (!arst_n)
		32'(tcnt_q) == $countones(tvalid_q))
		else $error("allocated count disagrees with valid bits");

	// A new allocation never overwrites a live table entry.
	a_tk_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		tk_we |-> !tvalid_q[tk_waddr])
		else $error("allocation overwrites a live entry");

	// Free list writes stay within the used entries plus one.
	a_fr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fr_we |-> {1'b0, fr_waddr} < ({1'b0, used_q} + 1'b1))
		else $error("free list write beyond the list end");

endmodule

FILE: rtl/first_fit_heap_allocator_top.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_top: first-fit heap allocator with coalescing
// Manages byte offsets of a heap through an address-ordered free list and a
// table of allocated blocks, both held in synchronous memories.
// ----------------------------------------------------------------------------
// Usage:
// Requests enter on req (func, request_bytes, block_address) and one result
// word per request leaves on rsp. Both are valid/ready channels.
// One request is worked on at a time. The time a request takes grows with the
// free list entries scanned (allocate, free), the allocated table entries
// scanned (free, get size) and the entries moved when the free list closes or
// opens a gap; the single read port of each memory sets the pace.
// The result sits in an output register, so a new request is taken while the
// previous result still waits; a stalled receiver holds back only the next
// result. A write on cfg_wen sets the heap size and re-initialises the heap;
// reset does the same with a 65536-byte heap.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_top #(
	parameter int FREE_SLOTS   = 32,
	parameter int TAKEN_SLOTS  = 32,
	parameter int ALIGN_BYTES  = 8,
	parameter int HEADER_BYTES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	ffa_req_if.sink     req,
	ffa_rsp_if.source   rsp,
	input  logic        cfg_wen,
	input  logic [16:0] cfg_wdata
);

	localparam int FI_W = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
	localparam int TI_W = (TAKEN_SLOTS > 1) ? $clog2(TAKEN_SLOTS) : 1;

	logic                fr_we;
	logic [FI_W-1:0]     fr_waddr;
	logic [FI_W-1:0]     fr_raddr;
	ffa_pkg::ffa_entry_t fr_wdata;
	ffa_pkg::ffa_entry_t fr_rdata;
	logic                tk_we;
	logic [TI_W-1:0]     tk_waddr;
	logic [TI_W-1:0]     tk_raddr;
	ffa_pkg::ffa_entry_t tk_wdata;
	ffa_pkg::ffa_entry_t tk_rdata;

	// Free list memory.
	ffa_ram #(
		.DEPTH (FREE_SLOTS),
		.WIDTH ($bits(ffa_pkg::ffa_entry_t)),
		.AW    (FI_W)
	) u_free_ram (
		.clk   (clk),
		.we    (fr_we),
		.waddr (fr_waddr),
		.wdata (fr_wdata),
		.raddr (fr_raddr),
		.rdata (fr_rdata)
	);

	// Allocated block table memory.
	ffa_ram #(
		.DEPTH (TAKEN_SLOTS),
		.WIDTH ($bits(ffa_pkg::ffa_entry_t)),
		.AW    (TI_W)
	) u_taken_ram (
		.clk   (clk),
		.we    (tk_we),
		.waddr (tk_waddr),
		.wdata (tk_wdata),
		.raddr (tk_raddr),
		.rdata (tk_rdata)
	);

	// Sequencer.
	ffa_seq #(
		.FREE_SLOTS   (FREE_SLOTS),
		.TAKEN_SLOTS  (TAKEN_SLOTS),
		.ALIGN_BYTES  (ALIGN_BYTES),
		.HEADER_BYTES (HEADER_BYTES),
		.FI_W         (FI_W),
		.TI_W         (TI_W)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.fr_we     (fr_we),
		.fr_waddr  (fr_waddr),
		.fr_wdata  (fr_wdata),
		.fr_raddr  (fr_raddr),
		.fr_rdata  (fr_rdata),
		.tk_we     (tk_we),
		.tk_waddr  (tk_waddr),
		.tk_wdata  (tk_wdata),
		.tk_raddr  (tk_raddr),
		.tk_rdata  (tk_rdata)
	);

endmodule

FILE: test/ffa_tb_if.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ffa_tb_if: testbench side of the allocator channels
// The channel interfaces are declared with the RTL; this file only holds the
// small helper shared by the testbench, the record of one expected word.
// ----------------------------------------------------------------------------
package ffa_tb_pkg;

	// One expected result word.
	typedef struct {
		logic [15:0] granted_address;
		logic [15:0] block_bytes;
		logic        ok;
		logic [1:0]  error_code;
		logic [15:0] total_free_bytes;
		logic [5:0]  fragment_count;
	} ffa_result_t;

endpackage

FILE: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the first-fit heap allocator
// A directed table followed by random allocate, free, size and status traffic drives
// the request channel; a behavioural copy of the allocator predicts every
// result word, which is compared field by field as it leaves the block.
// ----------------------------------------------------------------------------
module tb;

	localparam int FREE_N  = 32;
	localparam int TAKEN_N = 32;
	localparam int ALIGN   = 8;
	localparam int HDR     = 8;
	localparam int IDLE_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        cfg_wen;
	logic [16:0] cfg_wdata;

	ffa_req_if req ();
	ffa_rsp_if rsp ();

	first_fit_heap_allocator_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req.sink),
		.rsp       (rsp.source),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata)
	);

	// Predicted heap state.
	int unsigned  free_at[FREE_N];
	int unsigned  free_len[FREE_N];
	int unsigned  free_count;
	int unsigned  held_at[TAKEN_N];
	int unsigned  held_len[TAKEN_N];
	bit           held_on[TAKEN_N];

	ffa_tb_pkg::ffa_result_t pending[$];
	int unsigned  mismatches;
	int unsigned  words_sent;
	int unsigned  words_seen;
	int unsigned  idle_cycles;
	bit           hold_off;
	bit           sending_done;
	int unsigned  n_alloc_ok, n_free_ok, n_errors;

	// Directed stimulus; expectations typed in only where obvious.
	typedef struct {
		logic [1:0]  func;
		logic [16:0] bytes;
		logic [15:0] addr;
		bit          typed;
		ffa_tb_pkg::ffa_result_t want;
	} step_row_t;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Re-initialises the predicted heap after reset or a size write.
	task automatic heap_reset(input int unsigned size);
		int unsigned eff;
		eff = (size > 65536) ? 65536 : size;
		free_count = 1;
		free_at[0] = 0;
		free_len[0] = (eff >= HDR) ? eff - HDR : 0;
		for (int k = 1; k < FREE_N; k++) begin
			free_at[k] = 0;
			free_len[k] = 0;
		end
		for (int k = 0; k < TAKEN_N; k++) held_on[k] = 1'b0;
	endtask

	function automatic int held_slot(input int unsigned a);
		for (int k = 0; k < TAKEN_N; k++)
			if (held_on[k] && held_at[k] + HDR == a) return k;
		return -1;
	endfunction

	// Applies one request to the predicted heap and returns its result word.
	function automatic ffa_tb_pkg::ffa_result_t heap_step(input logic [1:0] f,
			input int unsigned b, input int unsigned a);
		ffa_tb_pkg::ffa_result_t r;
		int unsigned sz, i, s, p, e, idx, sum, gaddr, gbytes;
		int t;
		logic [1:0] err;
		bit mn, mp;
		gaddr = 0; gbytes = 0; err = ffa_pkg::ERR_NONE;
		case (f)
			ffa_pkg::FUNC_ALLOC: begin
				sz = ((b + ALIGN - 1) / ALIGN) * ALIGN;
				for (i = 0; i < free_count; i++) if (free_len[i] >= sz) break;
				t = -1;
				for (int k = 0; k < TAKEN_N; k++) if (!held_on[k]) begin t = k; break; end
				if (i >= free_count) err = ffa_pkg::ERR_NOFIT;
				else if (t < 0) err = ffa_pkg::ERR_FULL;
				else begin
					s = free_at[i];
					if (free_len[i] < sz + HDR) begin
						gbytes = free_len[i];
						for (int k = i; k + 1 < free_count; k++) begin
							free_at[k] = free_at[k+1];
							free_len[k] = free_len[k+1];
						end
						free_count--;
					end else begin
						gbytes = sz;
						free_at[i] += HDR + sz;
						free_len[i] -= HDR + sz;
					end
					held_on[t] = 1'b1;
					held_at[t] = s;
					held_len[t] = gbytes;
					gaddr = s + HDR;
				end
			end
			ffa_pkg::FUNC_FREE: begin
				t = held_slot(a);
				if (t < 0) err = ffa_pkg::ERR_UNKNOWN;
				else begin
					s = held_at[t];
					p = held_len[t];
					e = s + HDR + p;
					for (idx = 0; idx < free_count; idx++) if (free_at[idx] > s) break;
					mn = idx < free_count && free_at[idx] == e;
					mp = idx > 0 && free_at[idx-1] + HDR + free_len[idx-1] == s;
					if (mn && mp) begin
						free_len[idx-1] += 2 * HDR + p + free_len[idx];
						for (int k = idx; k + 1 < free_count; k++) begin
							free_at[k] = free_at[k+1];
							free_len[k] = free_len[k+1];
						end
						free_count--;
					end else if (mp) begin
						free_len[idx-1] += HDR + p;
					end else if (mn) begin
						free_at[idx] = s;
						free_len[idx] += p + HDR;
					end else if (free_count >= FREE_N) begin
						err = ffa_pkg::ERR_FULL;
					end else begin
						for (int k = free_count; k > idx; k--) begin
							free_at[k] = free_at[k-1];
							free_len[k] = free_len[k-1];
						end
						free_at[idx] = s;
						free_len[idx] = p;
						free_count++;
					end
					if (err == ffa_pkg::ERR_NONE) held_on[t] = 1'b0;
				end
			end
			ffa_pkg::FUNC_SIZE: begin
				t = held_slot(a);
				if (t < 0) err = ffa_pkg::ERR_UNKNOWN;
				else gbytes = held_len[t];
			end
			default: ;
		endcase
		sum = 0;
		for (i = 0; i < free_count; i++) sum += free_len[i];
		r.granted_address  = gaddr[15:0];
		r.block_bytes      = gbytes[15:0];
		r.ok               = (err == ffa_pkg::ERR_NONE);
		r.error_code       = err;
		r.total_free_bytes = sum[15:0];
		r.fragment_count   = 6'(free_count + 1);
		return r;
	endfunction

	function automatic ffa_tb_pkg::ffa_result_t typed_word(input logic [15:0] ga,
			input logic [15:0] bb, input logic [1:0] err, input logic [15:0] tot,
			input logic [5:0] fc);
		ffa_tb_pkg::ffa_result_t r;
		r.granted_address = ga;
		r.block_bytes = bb;
		r.ok = (err == ffa_pkg::ERR_NONE);
		r.error_code = err;
		r.total_free_bytes = tot;
		r.fragment_count = fc;
		return r;
	endfunction

	// Sends one word after a random gap and queues its expectation.
	// The word stays on the channel until the falling edge after its acceptance,
	// where it is either replaced by the next word or withdrawn.
	task automatic send_word(input logic [1:0] f, input logic [16:0] b, input logic [15:0] a,
			input bit typed, input ffa_tb_pkg::ffa_result_t want);
		ffa_tb_pkg::ffa_result_t pred;
		int unsigned gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
		@(negedge clk);
		if (gap != 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.valid <= 1'b1;
		req.func <= f;
		req.request_bytes <= b;
		req.block_address <= a;
		do @(posedge clk); while (!req.ready);
		pred = heap_step(f, b, a);
		if (typed && pred != want)
			$display("tb: table row disagrees with predictor, func %0d", f);
		pending.push_back(typed ? want : pred);
		if (pred.ok && f == ffa_pkg::FUNC_ALLOC) n_alloc_ok++;
		if (pred.ok && f == ffa_pkg::FUNC_FREE) n_free_ok++;
		if (!pred.ok) n_errors++;
		words_sent++;
	endtask

	// Waits for the block to drain, then writes a new heap size.
	task automatic set_heap(input logic [16:0] size);
		@(negedge clk);
		req.valid <= 1'b0;
		while (pending.size() != 0) @(negedge clk);
		repeat (120) @(negedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= size;
		@(negedge clk);
		cfg_wen <= 1'b0;
		heap_reset(size);
		@(negedge clk);
	endtask

	// Picks a live allocated address, or a random one.
	function automatic logic [15:0] some_address();
		int k;
		k = $urandom_range(0, TAKEN_N - 1);
		for (int j = 0; j < TAKEN_N; j++)
			if (held_on[(k + j) % TAKEN_N]) return 16'(held_at[(k + j) % TAKEN_N] + HDR);
		return 16'($urandom);
	endfunction

	// Random traffic on one heap size.
	task automatic random_phase(input int count, input int unsigned maxreq);
		ffa_tb_pkg::ffa_result_t none;
		int unsigned roll;
		logic [1:0] f;
		logic [16:0] b;
		logic [15:0] a;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(0, 99);
			b = 17'($urandom_range(0, maxreq));
			a = some_address();
			if (roll < 45) f = ffa_pkg::FUNC_ALLOC;
			else if (roll < 80) f = ffa_pkg::FUNC_FREE;
			else if (roll < 92) f = ffa_pkg::FUNC_SIZE;
			else f = ffa_pkg::FUNC_STATUS;
			if (roll >= 97) begin
				a = 16'($urandom);
				b = 17'($urandom);
			end
			send_word(f, b, a, 1'b0, none);
		end
	endtask

	// Stimulus.
	initial begin
		step_row_t rows[$];
		step_row_t row;
		ffa_tb_pkg::ffa_result_t none;
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_wdata = '0;
		req.valid = 1'b0;
		req.func = ffa_pkg::FUNC_STATUS;
		req.request_bytes = '0;
		req.block_address = '0;
		hold_off = 1'b0;
		sending_done = 1'b0;
		heap_reset(65536);
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (4) @(negedge clk);

		// Directed table on the reset heap.
		row.typed = 1'b1;
		row.func = ffa_pkg::FUNC_STATUS; row.bytes = 0; row.addr = 0;
		row.want = typed_word(0, 0, ffa_pkg::ERR_NONE, 16'(65528), 2); rows.push_back(row);
		row.func = ffa_pkg::FUNC_ALLOC; row.bytes = 17'h1FFFF;
		row.want = typed_word(0, 0, ffa_pkg::ERR_NOFIT, 16'(65528), 2); rows.push_back(row);
		row.func = ffa_pkg::FUNC_FREE; row.addr = 16'hFFFF;
		row.want = typed_word(0, 0, ffa_pkg::ERR_UNKNOWN, 16'(65528), 2); rows.push_back(row);
		row.func = ffa_pkg::FUNC_SIZE; row.addr = 0;
		row.want = typed_word(0, 0, ffa_pkg::ERR_UNKNOWN, 16'(65528), 2); rows.push_back(row);
		row.func = ffa_pkg::FUNC_ALLOC; row.bytes = 1;
		row.want = typed_word(8, 8, ffa_pkg::ERR_NONE, 16'(65512), 2); rows.push_back(row);
		row.func = ffa_pkg::FUNC_ALLOC; row.bytes = 0;
		row.want = typed_word(24, 0, ffa_pkg::ERR_NONE, 16'(65504), 2); rows.push_back(row);
		row.typed = 1'b0;
		row.func = ffa_pkg::FUNC_SIZE; row.addr = 8; rows.push_back(row);
		row.func = ffa_pkg::FUNC_ALLOC; row.bytes = 100; rows.push_back(row);
		row.func = ffa_pkg::FUNC_FREE; row.addr = 24; rows.push_back(row);
		row.func = ffa_pkg::FUNC_FREE; row.addr = 8; rows.push_back(row);
		row.func = ffa_pkg::FUNC_FREE; row.addr = 40; rows.push_back(row);
		row.func = ffa_pkg::FUNC_ALLOC; row.bytes = 65528; rows.push_back(row);
		row.func = ffa_pkg::FUNC_ALLOC; row.bytes = 0; rows.push_back(row);
		row.func = ffa_pkg::FUNC_FREE; row.addr = 0; rows.push_back(row);
		row.func = ffa_pkg::FUNC_FREE; row.addr = 8; rows.push_back(row);
		foreach (rows[k]) send_word(rows[k].func, rows[k].bytes, rows[k].addr,
			rows[k].typed, rows[k].want);

		// Fill the allocated table, then send frees whose block_address is 0, so each finds no block.
		set_heap(17'd4096);
		for (int k = 0; k < TAKEN_N + 2; k++)
			send_word(ffa_pkg::FUNC_ALLOC, 17'd16, 0, 1'b0, none);
		for (int k = 0; k < TAKEN_N; k += 2)
			send_word(ffa_pkg::FUNC_FREE, 16'(8 + k * 24), 0, 1'b0, none);

		// Smallest heap, below a header, then random traffic on a 64-byte heap and a clamped one.
		set_heap(17'd4);
		send_word(ffa_pkg::FUNC_ALLOC, 0, 0, 1'b0, none);
		send_word(ffa_pkg::FUNC_ALLOC, 1, 0, 1'b0, none);
		set_heap(17'd64);
		random_phase(40, 64);
		set_heap(17'h1FFFF);
		random_phase(20, 200);

		// Long receiver stall while requests keep coming.
		hold_off = 1'b1;
		random_phase(10, 600);
		hold_off = 1'b0;

		// Main random traffic: small heaps with many fragments, then a large one.
		set_heap(17'd2048);
		random_phase(450, 120);
		set_heap(17'd512);
		random_phase(350, 60);
		set_heap(17'd65536);
		random_phase(500, 4000);
		@(negedge clk);
		req.valid <= 1'b0;
		sending_done = 1'b1;
	end

	// Receiver: random back-pressure, with the long hold-off when asked.
	initial begin
		int unsigned wait_n;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				rsp.ready <= 1'b0;
				repeat (600) @(negedge clk);
			end
			wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
			if (wait_n != 0) begin
				rsp.ready <= 1'b0;
				repeat (wait_n) @(negedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!rsp.valid);
		end
	end

	// Result checker and watchdog.
	always @(posedge clk) begin
		ffa_tb_pkg::ffa_result_t w;
		if (arst_n) begin
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (rsp.valid && rsp.ready) begin
				words_seen <= words_seen + 1;
				if (pending.size() == 0) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10) $display("tb: unexpected result word");
				end else begin
					w = pending.pop_front();
					if (w.granted_address !== rsp.granted_address ||
							w.block_bytes !== rsp.block_bytes || w.ok !== rsp.ok ||
							w.error_code !== rsp.error_code ||
							w.total_free_bytes !== rsp.total_free_bytes ||
							w.fragment_count !== rsp.fragment_count) begin
						mismatches <= mismatches + 1;
						if (mismatches < 10)
							$display("tb: mismatch exp %h %h %b %h %h %h got %h %h %b %h %h %h",
								w.granted_address, w.block_bytes, w.ok, w.error_code,
								w.total_free_bytes, w.fragment_count, rsp.granted_address,
								rsp.block_bytes, rsp.ok, rsp.error_code,
								rsp.total_free_bytes, rsp.fragment_count);
					end
				end
			end
		end
	end

	initial begin
		mismatches = 0;
		words_sent = 0;
		words_seen = 0;
		idle_cycles = 0;
		n_alloc_ok = 0;
		n_free_ok = 0;
		n_errors = 0;
	end

	// End of run.
	initial begin
		@(posedge arst_n);
		while (!(sending_done && pending.size() == 0) && idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: timeout with %0d words outstanding", pending.size());
			$display("tb: FAIL");
		end else begin
			repeat (200) @(posedge clk);
			$display("tb: %0d requests, %0d grants, %0d frees, %0d error results",
				words_sent, n_alloc_ok, n_free_ok, n_errors);
			$display("tb: %0d result words checked, %0d mismatches", words_seen, mismatches);
			if (mismatches == 0 && pending.size() == 0) $display("tb: PASS");
			else $display("tb: FAIL");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/ffa_pkg.sv
rtl/ffa_if.sv
rtl/ffa_ram.sv
rtl/ffa_seq.sv
rtl/first_fit_heap_allocator_top.sv
test/ffa_tb_if.sv
test/tb.sv
